FILE: rtl/twma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_pkg : shared types and constants
// Field widths, register indexes, sequencer states and the divider status
// word used across the moving average block.
// ----------------------------------------------------------------------------
package twma_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TICK_W     = 32;
   localparam int AVG_W      = 16;
   localparam int WINDOW_W   = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes on the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_INTERVAL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LENGTH   = 2'd1;

   localparam logic [TICK_W-1:0]   INTERVAL_RESET = 32'd100;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 5'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CHECK,
      ST_WRITE,
      ST_SUM,
      ST_DIV,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: rtl/twma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_if : channel interfaces
// Request, response and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface twma_req_if;
   import twma_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_value;
   logic [TICK_W-1:0]   tick_now;

   modport source (output valid, output sample_value, output tick_now, input ready);
   modport sink   (input valid, input sample_value, input tick_now, output ready);
endinterface

interface twma_rsp_if;
   import twma_pkg::*;

   logic             valid;
   logic             ready;
   logic [AVG_W-1:0] average_value;
   logic             sample_taken;

   modport source (output valid, output average_value, output sample_taken, input ready);
   modport sink   (input valid, input average_value, input sample_taken, output ready);
endinterface

interface twma_csr_if;
   import twma_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/timed_windowed_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_windowed_moving_average_core : rate-limited windowed moving average
// Takes samples no more often than the programmed tick interval and reports
// the average of the most recent window of taken samples with every word.
// ----------------------------------------------------------------------------
// Each request word carries a sample and the current free-running tick. The
// sample joins the window only if the tick has moved on by more than
// sample_interval (modulo 2^32) since the last taken sample; the response
// word then carries the new truncated average and sample_taken = 1, otherwise
// the previous average and sample_taken = 0. The core takes one request at a
// time. When the sample is taken, the work is set by reading the ring one
// entry per cycle through its single read port and by the divider producing
// one quotient bit per cycle. The response sits in an output register, so
// the core goes back to accepting requests while the previous result waits.
// Write configuration only while the core is idle; the configuration channel
// is always ready.
// ----------------------------------------------------------------------------
module timed_windowed_moving_average_core #(
   parameter int RING_DEPTH  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   twma_req_if.sink    req_bus,
   twma_rsp_if.source  rsp_bus,
   twma_csr_if.sink    csr_bus
);
   import twma_pkg::*;

   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + FILL_W;
   localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(RING_DEPTH);

   // sequencer
   state_type state_ff, state_in;

   // configuration
   logic [TICK_W-1:0]   interval_ff, interval_in;
   logic [WINDOW_W-1:0] window_ff, window_in;

   // captured request word and intermediate results
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [TICK_W-1:0]      elapsed_ff, elapsed_in;
   logic                   taken_ff, taken_in;

   // window state
   logic [TICK_W-1:0] last_tick_ff, last_tick_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [AVG_W-1:0]  held_ff, held_in;

   // summing pass
   logic [FILL_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic             rsp_taken_ff, rsp_taken_in;

   // combinational helpers
   logic [FILL_W-1:0]      win;
   logic [FILL_W-1:0]      idx_next;
   logic                   sum_done;
   logic                   load_ok;
   logic                   ram_we;
   logic [SAMPLE_BITS-1:0] ram_rdata;
   logic                   div_start;
   div_status_type         div_stat;
   logic [SUM_W-1:0]       div_quot;

   // ring of taken samples
   twma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_idx_ff),
      .wdata (sample_ff),
      .raddr (rd_cnt_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   // divider for sum / fill count
   twma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (fill_ff),
      .status   (div_stat),
      .quotient (div_quot)
   );

   // Clamp the programmed window into 1 .. RING_DEPTH.
   always_comb begin
      if (window_ff == '0) begin
         win = FILL_W'(1);
      end else if ({27'd0, window_ff} > 32'(RING_DEPTH)) begin
         win = DEPTH_F;
      end else begin
         win = FILL_W'(window_ff);
      end
   end

   assign sum_done = (rd_cnt_ff == fill_ff) && !rd_pend_ff;
   assign load_ok  = !rsp_valid_ff || rsp_bus.ready;
   assign idx_next = FILL_W'(wr_idx_ff) + FILL_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) state_in = ST_DIFF;
         end
         ST_DIFF: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (elapsed_ff > interval_ff) ? ST_WRITE : ST_LOAD;
         end
         ST_WRITE: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load_ok) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      interval_in  = interval_ff;
      window_in    = window_ff;
      sample_in    = sample_ff;
      tick_in      = tick_ff;
      elapsed_in   = elapsed_ff;
      taken_in     = taken_ff;
      last_tick_in = last_tick_ff;
      fill_in      = fill_ff;
      wr_idx_in    = wr_idx_ff;
      held_in      = held_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_pend_in   = 1'b0;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_taken_in = rsp_taken_ff;
      ram_we       = 1'b0;
      div_start    = 1'b0;

      // configuration writes; other indexes are ignored
      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_SAMPLE_INTERVAL) begin
            interval_in = csr_bus.data;
         end else if (csr_bus.index == CSR_WINDOW_LENGTH) begin
            window_in = csr_bus.data[WINDOW_W-1:0];
         end
      end

      // retire the response word once taken downstream
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // capture the request word; keep only SAMPLE_BITS of the sample
            if (req_bus.valid) begin
               sample_in = SAMPLE_BITS'(req_bus.sample_value);
               tick_in   = req_bus.tick_now;
            end
         end
         ST_DIFF: begin
            elapsed_in = tick_ff - last_tick_ff;
         end
         ST_CHECK: begin
            taken_in = (elapsed_ff > interval_ff);
         end
         ST_WRITE: begin
            // store the sample, grow the fill and advance the write index
            ram_we       = 1'b1;
            last_tick_in = tick_ff;
            fill_in      = (fill_ff < win) ? fill_ff + FILL_W'(1) : win;
            wr_idx_in    = (idx_next >= win) ? '0 : idx_next[IDX_W-1:0];
            rd_cnt_in    = '0;
            acc_in       = '0;
         end
         ST_SUM: begin
            // issue one read per cycle, add each entry when its registered read data returns
            if (rd_cnt_ff != fill_ff) begin
               rd_cnt_in  = rd_cnt_ff + FILL_W'(1);
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               acc_in = acc_ff + SUM_W'(ram_rdata);
            end
            if (sum_done) begin
               div_start = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               held_in = AVG_W'(div_quot);
            end
         end
         ST_LOAD: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = held_ff;
               rsp_taken_in = taken_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= INTERVAL_RESET;
         window_ff    <= WINDOW_RESET;
         last_tick_ff <= '0;
         fill_ff      <= '0;
         wr_idx_ff    <= '0;
         held_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         window_ff    <= window_in;
         last_tick_ff <= last_tick_in;
         fill_ff      <= fill_in;
         wr_idx_ff    <= wr_idx_in;
         held_ff      <= held_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      tick_ff      <= tick_in;
      elapsed_ff   <= elapsed_in;
      taken_ff     <= taken_in;
      rd_cnt_ff    <= rd_cnt_in;
      acc_ff       <= acc_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_taken_ff <= rsp_taken_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.average_value = rsp_avg_ff;
   assign rsp_bus.sample_taken  = rsp_taken_ff;
endmodule

FILE: rtl/twma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module twma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/twma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twma_div : iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module twma_div #(
   parameter int DIVIDEND_W = 21,
   parameter int DIVISOR_W  = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIVIDEND_W-1:0]       dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output twma_pkg::div_status_type    status,
   output logic [DIVIDEND_W-1:0]       quotient
);
   import twma_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0] trial;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});

      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = STEP_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dvd_ff;
endmodule
